@@ hw/rtl/sgs_pkg.sv @@
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared types and constants of the SRPT grant scheduler.
// ----------------------------------------------------------------------------
package sgs_pkg;

   localparam int MAX_FLOWS      = 64;
   localparam int MAX_OVERCOMMIT = 8;
   localparam int IDX_W          = $clog2(MAX_FLOWS);
   localparam int CNT_W          = $clog2(MAX_FLOWS + 1);
   localparam int OC_W           = 4;
   localparam int RTT_W          = 24;
   localparam int CSR_W          = RTT_W;

   localparam logic [RTT_W-1:0] RTT_RESET        = RTT_W'(10000);
   localparam logic [OC_W-1:0]  OVERCOMMIT_RESET = OC_W'(2);

   // register indexes
   localparam logic CSR_RTT        = 1'b0;
   localparam logic CSR_OVERCOMMIT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_GRANT    = 2'd0,
      STATUS_COMPLETE = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] flow_id;
      logic [31:0] msg_size;
      logic [31:0] recvd_bytes;
   } req_type;

   typedef struct packed {
      logic [15:0] grant_flow_id;
      logic [31:0] grant_offset;
      logic [2:0]  grant_priority;
      status_type  status;
      logic [6:0]  active_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] flow;
      logic [31:0] size;
      logic [31:0] received;
      logic [31:0] granted;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RANK,
      ST_GRANT,
      ST_FINISH
   } state_type;

endpackage

@@ hw/rtl/sgs_table.sv @@
// ----------------------------------------------------------------------------
// sgs_table
// Flow table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgs_table
   import sgs_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_FLOWS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/srpt_grant_scheduler.sv @@
// ----------------------------------------------------------------------------
// srpt_grant_scheduler
// Receiver-side SRPT grant scheduler over a 64-entry flow table.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one item per data-packet arrival (flow id, message size, bytes
//    received). req_ready is high only while the sequencer is idle.
//  - rsp_*: zero to nine result items per arrival; the last one carries
//    last = 1. An arrival that causes nothing gives no item.
//  - csr_*: write-only registers (rtt_bytes, overcommit_level), written
//    while the block is idle.
//  - Sequence: one table sweep to find the flow and a free slot, an update
//    step, then for each of the k ranks a sweep plus a grant step, and a
//    closing step; k = min(active flows, overcommit_level capped at 8).
//    The single table read port, one entry a cycle, sets the sweep length.
//  - Results pass through a one-item hold register and the output register;
//    when the receiver stalls, the sequencer waits in the grant or closing
//    step. The next arrival is taken while the final item still waits.
//  - Reset clears all valid bits and the registers to their defaults.
// ----------------------------------------------------------------------------
module srpt_grant_scheduler
   import sgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   // control state
   state_type              state_ff,       state_in;
   logic [CNT_W-1:0]       cnt_ff,         cnt_in;
   logic                   rd_vld_ff,      rd_vld_in;
   logic [MAX_FLOWS-1:0]   valid_ff,       valid_in;
   logic [MAX_FLOWS-1:0]   picked_ff,      picked_in;
   logic [CNT_W-1:0]       count_ff,       count_in;
   logic                   slot_found_ff,  slot_found_in;
   logic                   free_found_ff,  free_found_in;
   logic                   best_found_ff,  best_found_in;
   logic [OC_W-1:0]        k_ff,           k_in;
   logic [OC_W-1:0]        rank_ff,        rank_in;
   logic                   pend_valid_ff,  pend_valid_in;
   logic                   rsp_valid_ff,   rsp_valid_in;
   logic [RTT_W-1:0]       rtt_ff,         rtt_in;
   logic [OC_W-1:0]        oc_ff,          oc_in;

   // payload
   req_type                req_ff,         req_in;
   logic [IDX_W-1:0]       rd_idx_ff,      rd_idx_in;
   logic [IDX_W-1:0]       slot_idx_ff,    slot_idx_in;
   logic [31:0]            slot_grant_ff,  slot_grant_in;
   logic [IDX_W-1:0]       free_idx_ff,    free_idx_in;
   logic [IDX_W-1:0]       best_idx_ff,    best_idx_in;
   logic [31:0]            best_rem_ff,    best_rem_in;
   entry_type              best_ff,        best_in;
   rsp_type                pend_ff,        pend_in;
   rsp_type                rsp_ff,         rsp_in;

   // table port
   logic                   rd_en;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;
   entry_type              rd_data;

   // shared arithmetic
   logic [31:0]            rem;
   logic [32:0]            want_sum;
   logic [31:0]            want;
   logic [OC_W-1:0]        lim;
   logic                   out_free;
   logic                   proc_v;

   sgs_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign rem      = rd_data.size - rd_data.received;
   assign want_sum = {1'b0, best_ff.received} + {9'b0, rtt_ff};
   assign want     = (want_sum > {1'b0, best_ff.size}) ? best_ff.size : want_sum[31:0];
   assign lim      = (oc_ff > OC_W'(MAX_OVERCOMMIT)) ? OC_W'(MAX_OVERCOMMIT) : oc_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign proc_v   = valid_ff[rd_idx_ff];

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      picked_in     = picked_ff;
      count_in      = count_ff;
      slot_found_in = slot_found_ff;
      free_found_in = free_found_ff;
      best_found_in = best_found_ff;
      k_in          = k_ff;
      rank_in       = rank_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rtt_in        = rtt_ff;
      oc_in         = oc_ff;
      req_in        = req_ff;
      slot_idx_in   = slot_idx_ff;
      slot_grant_in = slot_grant_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_rem_in   = best_rem_ff;
      best_in       = best_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_idx_ff;
      wr_data       = '{flow: req_ff.flow_id, size: req_ff.msg_size,
                        received: req_ff.recvd_bytes, granted: req_ff.recvd_bytes};

      if (csr_we) begin
         case (csr_index)
            CSR_RTT:        rtt_in = csr_wdata[RTT_W-1:0];
            CSR_OVERCOMMIT: oc_in  = csr_wdata[OC_W-1:0];
            default:        ;
         endcase
      end

      // table sweep: read entry cnt, judge the registered result of the previous read
      if ((state_ff == ST_LOOKUP || state_ff == ST_RANK) && cnt_ff < CNT_W'(MAX_FLOWS)) begin
         rd_en  = 1'b1;
         cnt_in = cnt_ff + CNT_W'(1);
      end
      rd_vld_in = rd_en;
      rd_idx_in = cnt_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               cnt_in        = '0;
               slot_found_in = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            if (rd_vld_ff) begin
               if (proc_v && !slot_found_ff && rd_data.flow == req_ff.flow_id) begin
                  slot_found_in = 1'b1;
                  slot_idx_in   = rd_idx_ff;
                  slot_grant_in = rd_data.granted;
               end
               if (!proc_v && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
            end
            if (cnt_ff == CNT_W'(MAX_FLOWS)) begin
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            pend_in = '{grant_flow_id: req_ff.flow_id, grant_offset: '0,
                        grant_priority: '0, status: STATUS_COMPLETE,
                        active_count: '0, last: 1'b0};
            if (req_ff.recvd_bytes >= req_ff.msg_size) begin
               pend_valid_in = 1'b1;
               if (slot_found_ff) begin
                  valid_in[slot_idx_ff] = 1'b0;
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (slot_found_ff) begin
               wr_en = 1'b1;
               if (slot_grant_ff > req_ff.recvd_bytes) begin
                  wr_data.granted = slot_grant_ff;
               end
            end else if (free_found_ff) begin
               // new flow: granted starts at zero, raised to received
               wr_en   = 1'b1;
               wr_addr = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               pend_valid_in  = 1'b1;
               pend_in.status = STATUS_FULL;
            end
            k_in          = (count_in < CNT_W'(lim)) ? OC_W'(count_in) : lim;
            rank_in       = '0;
            picked_in     = '0;
            cnt_in        = '0;
            best_found_in = 1'b0;
            state_in      = (k_in == '0) ? ST_FINISH : ST_RANK;
         end

         ST_RANK: begin
            if (rd_vld_ff && proc_v && !picked_ff[rd_idx_ff]) begin
               if (!best_found_ff || rem < best_rem_ff ||
                   (rem == best_rem_ff && rd_data.flow < best_ff.flow)) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_rem_in   = rem;
                  best_in       = rd_data;
               end
            end
            if (cnt_ff == CNT_W'(MAX_FLOWS)) begin
               state_in = ST_GRANT;
            end
         end

         ST_GRANT: begin
            // a new item needs the held one moved out first
            if (!(want > best_ff.granted && pend_valid_ff && !out_free)) begin
               picked_in[best_idx_ff] = 1'b1;
               if (want > best_ff.granted) begin
                  wr_en           = 1'b1;
                  wr_addr         = best_idx_ff;
                  wr_data         = best_ff;
                  wr_data.granted = want;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                     rsp_in.active_count = 7'(count_ff);
                  end
                  pend_valid_in = 1'b1;
                  pend_in = '{grant_flow_id: best_ff.flow, grant_offset: want,
                              grant_priority: 3'(k_ff - OC_W'(1) - rank_ff),
                              status: STATUS_GRANT, active_count: '0, last: 1'b0};
               end
               rank_in       = rank_ff + OC_W'(1);
               cnt_in        = '0;
               best_found_in = 1'b0;
               state_in      = (rank_in == k_ff) ? ST_FINISH : ST_RANK;
            end
         end

         ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = pend_ff;
               rsp_in.active_count = 7'(count_ff);
               rsp_in.last         = 1'b1;
               pend_valid_in       = 1'b0;
               state_in            = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         picked_ff     <= '0;
         count_ff      <= '0;
         slot_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         k_ff          <= '0;
         rank_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rtt_ff        <= RTT_RESET;
         oc_ff         <= OVERCOMMIT_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         picked_ff     <= picked_in;
         count_ff      <= count_in;
         slot_found_ff <= slot_found_in;
         free_found_ff <= free_found_in;
         best_found_ff <= best_found_in;
         k_ff          <= k_in;
         rank_ff       <= rank_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rtt_ff        <= rtt_in;
         oc_ff         <= oc_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rd_idx_ff     <= rd_idx_in;
      slot_idx_ff   <= slot_idx_in;
      slot_grant_ff <= slot_grant_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_rem_ff   <= best_rem_in;
      best_ff       <= best_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SRPT grant scheduler: a directed opening, then
// random flow traffic over several register settings, checked item by item
// against a cycle-free model of the flow table and ranking.
// ----------------------------------------------------------------------------
module tb_top;
   import sgs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // drain allowance after the last result: one full arrival at k = 8
   localparam int SETTLE_CYCLES = 700;

   typedef struct {
      logic [15:0] id;
      logic [31:0] size;
      logic [31:0] recvd;
   } flow_track_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;

   // model of the flow table and registers
   logic            tbl_valid [MAX_FLOWS];
   entry_type       tbl       [MAX_FLOWS];
   logic [23:0]     rtt_cfg;
   logic [3:0]      overcommit_cfg;

   req_type         arrival_q [$];   // items waiting to be offered
   rsp_type         grant_q   [$];   // grants and notices still to arrive
   flow_track_type  open_q    [$];   // flows mid-message in the generator

   int send_max;      // upper bound of the sender's gap per item
   int recv_max;      // upper bound of the receiver's stall per item
   int send_wait;
   int recv_wait;
   logic rx_hold;     // long receiver hold-off
   logic rx_hold_go;
   int mismatches;

   srpt_grant_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of one arrival: table update, then SRPT ranking of the k shortest
   // flows. Results go to grant_q in the order the block must send them.
   // ------------------------------------------------------------------------
   function automatic void schedule_arrival(req_type r);
      int          slot;
      int          free_slot;
      int          best;
      int unsigned active;
      int unsigned lim;
      int unsigned k;
      logic [31:0] rem;
      logic [31:0] best_rem;
      logic [32:0] want;
      logic        picked [MAX_FLOWS];
      rsp_type     res [$];
      rsp_type     one;

      slot = -1;
      free_slot = -1;
      best_rem = '0;
      for (int i = 0; i < MAX_FLOWS; i++) begin
         picked[i] = 1'b0;
         if (tbl_valid[i]) begin
            if (slot < 0 && tbl[i].flow == r.flow_id) slot = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end

      one = '0;
      one.grant_flow_id = r.flow_id;
      if (r.recvd_bytes >= r.msg_size) begin
         // completion: entry leaves the table, no slot needed
         if (slot >= 0) tbl_valid[slot] = 1'b0;
         one.status = STATUS_COMPLETE;
         res = {res, one};
      end else begin
         if (slot < 0 && free_slot >= 0) begin
            slot = free_slot;
            tbl_valid[slot] = 1'b1;
            tbl[slot].flow = r.flow_id;
            tbl[slot].granted = '0;
         end
         if (slot >= 0) begin
            tbl[slot].size = r.msg_size;
            tbl[slot].received = r.recvd_bytes;
            if (tbl[slot].granted < r.recvd_bytes) tbl[slot].granted = r.recvd_bytes;
         end else begin
            // table full: rejected, but ranking still runs
            one.status = STATUS_FULL;
            res = {res, one};
         end
      end

      active = 0;
      for (int i = 0; i < MAX_FLOWS; i++) if (tbl_valid[i]) active++;
      lim = (overcommit_cfg > MAX_OVERCOMMIT) ? MAX_OVERCOMMIT : overcommit_cfg;
      k = (active < lim) ? active : lim;

      for (int unsigned rank = 0; rank < k; rank++) begin
         best = -1;
         for (int i = 0; i < MAX_FLOWS; i++) begin
            if (tbl_valid[i] && !picked[i]) begin
               rem = tbl[i].size - tbl[i].received;
               if (best < 0 || rem < best_rem ||
                   (rem == best_rem && tbl[i].flow < tbl[best].flow)) begin
                  best = i;
                  best_rem = rem;
               end
            end
         end
         if (best >= 0) begin
            picked[best] = 1'b1;
            want = {1'b0, tbl[best].received} + {9'd0, rtt_cfg};
            if (want > {1'b0, tbl[best].size}) want = {1'b0, tbl[best].size};
            if (want > {1'b0, tbl[best].granted}) begin
               tbl[best].granted = want[31:0];
               one = '0;
               one.grant_flow_id = tbl[best].flow;
               one.grant_offset = want[31:0];
               one.grant_priority = 3'(k - 1 - rank);
               one.status = STATUS_GRANT;
               res = {res, one};
            end
         end
      end

      foreach (res[i]) begin
         res[i].active_count = 7'(active);
         res[i].last = (i == res.size() - 1);
         grant_q = {grant_q, res[i]};
      end
   endfunction

   // ------------------------------------------------------------------------
   // Sender: offers items from arrival_q, random gap after each acceptance.
   // The model is stepped on the accepting edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_wait = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            schedule_arrival(req_data);
            offer = 1'b0;
            send_wait = $urandom_range(0, send_max);
         end
         if (!offer) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (arrival_q.size() > 0) begin
               req_data <= arrival_q.pop_front();
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall after each item, plus the long hold-off; checks
   // every accepted result against the oldest expectation.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type exp_item;
      logic    take;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            recv_wait = $urandom_range(0, recv_max);
            if (grant_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item: flow %0h offset %0h status %0d",
                           rsp_data.grant_flow_id, rsp_data.grant_offset,
                           rsp_data.status);
            end else begin
               exp_item = grant_q.pop_front();
               if (rsp_data !== exp_item) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp flow %0h off %0h prio %0d st %0d cnt %0d last %0b",
                               " / got flow %0h off %0h prio %0d st %0d cnt %0d last %0b"},
                              exp_item.grant_flow_id, exp_item.grant_offset,
                              exp_item.grant_priority, exp_item.status,
                              exp_item.active_count, exp_item.last,
                              rsp_data.grant_flow_id, rsp_data.grant_offset,
                              rsp_data.grant_priority, rsp_data.status,
                              rsp_data.active_count, rsp_data.last);
               end
            end
         end
         if (rx_hold) begin
            take = 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_ready <= take;
      end
   end

   // long receiver hold-off, timed in its own process
   initial begin
      rx_hold <= 1'b0;
      @(posedge clock iff rx_hold_go);
      rx_hold <= 1'b1;
      repeat (2500) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_item(logic [15:0] id, logic [31:0] size, logic [31:0] recvd);
      req_type r;
      r.flow_id = id;
      r.msg_size = size;
      r.recvd_bytes = recvd;
      arrival_q = {arrival_q, r};
   endtask

   function automatic logic [31:0] pick_size();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return $urandom_range(1, 40000);
      else if (sel < 8) return $urandom;
      else return 32'hFFFF_FFFF - $urandom_range(0, 20000);
   endfunction

   // a new flow, usually starting near zero
   task automatic open_flow(logic [31:0] size);
      flow_track_type f;
      f.id = 16'($urandom_range(0, 65535));
      f.size = size;
      f.recvd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : 32'd0;
      if (f.recvd >= f.size) f.recvd = 32'd0;
      queue_item(f.id, f.size, f.recvd);
      if (f.recvd < f.size) open_q = {open_q, f};
   endtask

   // mostly well-formed message progress, some noise and broken sequences
   task automatic random_item();
      int unsigned sel;
      int unsigned idx;
      logic [32:0] nxt;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         queue_item(16'($urandom_range(0, 65535)), $urandom, $urandom);
      end else if (sel < 15 && open_q.size() > 0) begin
         // stale or rewound progress on a known flow
         idx = $urandom_range(0, open_q.size() - 1);
         queue_item(open_q[idx].id, open_q[idx].size,
                    $urandom_range(0, open_q[idx].recvd));
      end else if (open_q.size() < 6 || sel < 30) begin
         open_flow(pick_size());
      end else begin
         idx = $urandom_range(0, open_q.size() - 1);
         if ($urandom_range(0, 7) == 0)
            nxt = {1'b0, open_q[idx].size};
         else
            nxt = {1'b0, open_q[idx].recvd} + $urandom_range(1, 6000);
         if (nxt >= {1'b0, open_q[idx].size}) begin
            queue_item(open_q[idx].id, open_q[idx].size, open_q[idx].size);
            open_q.delete(idx);
         end else begin
            open_q[idx].recvd = nxt[31:0];
            queue_item(open_q[idx].id, open_q[idx].size, nxt[31:0]);
         end
      end
   endtask

   // block idle: nothing queued, nothing outstanding, last arrival finished
   task automatic wait_idle();
      while (arrival_q.size() > 0 || req_valid || grant_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_RTT) rtt_cfg = value[23:0];
      else overcommit_cfg = value[3:0];
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_RTT;
      csr_wdata  = '0;
      send_max   = 17;
      recv_max   = 17;
      rx_hold_go = 1'b0;
      mismatches = 0;
      rtt_cfg        = RTT_RESET;
      overcommit_cfg = OVERCOMMIT_RESET;
      for (int i = 0; i < MAX_FLOWS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and the special cases, reset settings
      queue_item(16'h0000, 32'd0, 32'd0);                    // empty message, absent
      queue_item(16'hFFFF, 32'hFFFF_FFFF, 32'd0);            // widest values
      queue_item(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);    // sum capped at size
      queue_item(16'h1234, 32'd5000, 32'd100);               // grant capped at size
      queue_item(16'h1234, 32'd5000, 32'd200);               // no new grant
      queue_item(16'h0001, 32'd5000, 32'd100);               // second flow of the same size
      queue_item(16'h1234, 32'd5000, 32'd6000);              // overshoot completes
      queue_item(16'hFFFF, 32'd1, 32'hFFFF_FFFF);            // completion, present
      queue_item(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);    // completion at max
      queue_item(16'h0001, 32'd5000, 32'd5000);              // exact completion
      queue_item(16'hAAAA, 32'h5555_5555, 32'h2AAA_AAAA);
      queue_item(16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
      wait_idle();

      // widest window, full overcommit, no idling on either side
      write_reg(CSR_RTT, 24'hFF_FFFF);
      write_reg(CSR_OVERCOMMIT, CSR_W'(8));
      send_max = 0;
      recv_max = 0;
      repeat (50) random_item();
      wait_idle();

      // overcommit one, zero window; block fills behind a long receiver stall
      write_reg(CSR_RTT, 24'd0);
      write_reg(CSR_OVERCOMMIT, CSR_W'(1));
      send_max = 17;
      recv_max = 17;
      @(posedge clock);
      rx_hold_go <= 1'b1;
      send_max = 0;
      repeat (50) random_item();
      while (arrival_q.size() > 30) @(posedge clock);
      send_max = 17;
      wait_idle();

      // overcommit zero: only notices
      write_reg(CSR_OVERCOMMIT, CSR_W'(0));
      write_reg(CSR_RTT, 24'd1500);
      repeat (20) random_item();
      wait_idle();

      // overcommit beyond the maximum saturates; fill the table past full
      write_reg(CSR_OVERCOMMIT, CSR_W'(15));
      recv_max = 5;
      repeat (70) open_flow($urandom | 32'h8000_0000);
      repeat (40) begin
         if (open_q.size() > 0) begin
            queue_item(open_q[0].id, open_q[0].size, open_q[0].size);
            void'(open_q.pop_front());
         end
      end
      wait_idle();

      if (mismatches == 0)
         $display("srpt_grant_scheduler test passed");
      else
         $display("srpt_grant_scheduler test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("srpt_grant_scheduler test failed");
      $finish;
   end

endmodule
